// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam logic [2:0] MODE_GRAY    = 3'd0;
    localparam logic [2:0] MODE_SNAP    = 3'd1;
    localparam logic [2:0] MODE_CLASS   = 3'd2;
    localparam logic [2:0] MODE_SIGNED  = 3'd3;
    localparam logic [2:0] MODE_VERR    = 3'd4;
    localparam logic [2:0] MODE_SNAPTEX = 3'd5;

    localparam logic [1:0] REG_COLOR_MODE     = 2'd0;
    localparam logic [1:0] REG_TINT_FLOOR     = 2'd1;
    localparam logic [1:0] REG_OVERLAY_ENABLE = 2'd2;

    localparam logic [7:0] TINT_FLOOR_RST = 8'd64;
    localparam logic [7:0] OVERLAY_CLASS  = 8'd4;
    localparam logic [7:0] LEVEL_MIN      = 8'd40;

    localparam rgb_t NAVY  = '{r: 8'd12,  g: 8'd14,  b: 8'd40};
    localparam rgb_t BLACK = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
    localparam rgb_t VERR_LOW  = '{r: 8'd40,  g: 8'd200, b: 8'd60};
    localparam rgb_t VERR_MID  = '{r: 8'd230, g: 8'd210, b: 8'd30};
    localparam rgb_t VERR_HIGH = '{r: 8'd230, g: 8'd30,  b: 8'd30};

    // Largest hue channel of tinted classes 2..5 and ceil(2^24 / that value)
    localparam logic [7:0]  HUE_MAX    [4] = '{8'd204, 8'd224, 8'd245, 8'd230};
    localparam logic [16:0] GMIN_RECIP [4] = '{17'd82242, 17'd74899, 17'd68479, 17'd72945};

    function automatic rgb_t snap_rgb(input logic [7:0] v);
        rgb_t c;
        case (v)
            8'd0:    c = NAVY;
            8'd1:    c = '{r: 8'd110, g: 8'd110, b: 8'd110};
            8'd2:    c = '{r: 8'd33,  g: 8'd204, b: 8'd64};
            8'd3:    c = '{r: 8'd224, g: 8'd31,  b: 8'd31};
            8'd4:    c = '{r: 8'd245, g: 8'd140, b: 8'd25};
            8'd5:    c = '{r: 8'd230, g: 8'd217, b: 8'd38};
            default: c = BLACK;
        endcase
        return c;
    endfunction

    function automatic rgb_t class_rgb(input logic [7:0] v);
        rgb_t c;
        case (v)
            8'd0:    c = NAVY;
            8'd1:    c = '{r: 8'd150, g: 8'd150, b: 8'd150};
            8'd2:    c = '{r: 8'd220, g: 8'd30,  b: 8'd30};
            8'd3:    c = '{r: 8'd240, g: 8'd140, b: 8'd20};
            8'd4:    c = '{r: 8'd60,  g: 8'd90,  b: 8'd150};
            8'd5:    c = '{r: 8'd230, g: 8'd20,  b: 8'd210};
            8'd6:    c = '{r: 8'd30,  g: 8'd200, b: 8'd190};
            8'd7:    c = '{r: 8'd110, g: 8'd230, b: 8'd90};
            default: c = BLACK;
        endcase
        return c;
    endfunction

    // ceil(f * 255 / HUE_MAX[k]) capped at 255, by reciprocal multiplication
    function automatic logic [7:0] gmin_calc(input logic [7:0] f, input logic [1:0] k);
        logic [15:0] num;
        logic [32:0] prod;
        logic [8:0]  q;
        num  = ({f, 8'd0} - {8'd0, f}) + {8'd0, HUE_MAX[k] - 8'd1};
        prod = 33'(num) * 33'(GMIN_RECIP[k]);
        q    = prod[32:24];
        return (q > 9'd255) ? 8'd255 : q[7:0];
    endfunction

    // floor(x / 255) for x below 65280: x * (2^16 + 2^8 + 2) >> 24
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [32:0] s;
        s = 33'({x, 16'd0}) + 33'({x, 8'd0}) + 33'({x, 1'b0});
        return s[31:24];
    endfunction

    // floor(g * 3 / 10): x * 1639 >> 14 is exact for x below 1024
    function automatic logic [7:0] damp(input logic [7:0] g);
        logic [9:0]  x;
        logic [20:0] prod;
        x    = {1'b0, g, 1'b0} + {2'd0, g};
        prod = 21'(x) * 21'(11'd1639);
        return {1'b0, prod[20:14]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/diagnostic_pixel_colorizer.sv
// Diagnostic pixel colorizer: one RGB triple for each pixel item.
// Input channel in_valid/in_ready carries pixel_value and overlay_class;
// output channel out_valid/out_ready carries red, green and blue.
// Configuration channel cfg_valid/cfg_ready takes cfg_index and cfg_data:
// index 0 color_mode, 1 tint_floor, 2 overlay_enable; other indexes are ignored.
// cfg_ready is always high; write registers only while no item is in flight.
// A tint_floor write is not kept itself but loads the per-class snaptex
// minimum levels, which are computed from the written value in the same cycle.
// Each item passes through the input register, then the result register;
// out_valid rises when the result is loaded; a stalled result delays that.
// One item per cycle while the output is not stalled; the colour logic between
// the two registers is a single combinational pass.
// While out_ready is low a valid result holds and one more item may wait
// in the input register; in_ready falls only when both are full and stalled.
// Reset clears both valid flags and loads color_mode 0 (gray),
// tint_floor 64 and overlay_enable 0.
`default_nettype none

module diagnostic_pixel_colorizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] pixel_value,
    input  wire logic [7:0] overlay_class,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] red,
    output logic      [7:0] green,
    output logic      [7:0] blue,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);
    import dpc_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] pix_reg;
    logic [7:0] cls_reg;
    rgb_t       out_rgb_reg;
    rgb_t       out_rgb_next;

    logic [2:0] color_mode_reg;
    logic       overlay_enable_reg;
    logic [7:0] gmin_reg [4];

    logic       s2_ready;
    logic       in_fire;
    logic       s1_move;
    logic       cfg_fire;

    logic       tinted;
    logic [1:0] hue_idx;
    rgb_t       hue;
    logic [7:0] gmin_sel;
    logic [7:0] level;
    logic [7:0] lit;
    logic [7:0] ramp_t;
    logic [8:0] ramp_sum;
    rgb_t       base;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign s2_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign in_fire  = in_valid && in_ready;
    assign s1_move  = s1_valid_reg && s2_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s2_ready);
    assign out_valid_next = s2_ready ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pix_reg <= pixel_value;
            cls_reg <= overlay_class;
        end
        if (s1_move)
        begin
            out_rgb_reg <= out_rgb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg     <= MODE_GRAY;
            overlay_enable_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                gmin_reg[i] <= gmin_calc(TINT_FLOOR_RST, 2'(i));
            end
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_COLOR_MODE:
                begin
                    color_mode_reg <= cfg_data[2:0];
                end
                REG_TINT_FLOOR:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        gmin_reg[i] <= gmin_calc(cfg_data, 2'(i));
                    end
                end
                REG_OVERLAY_ENABLE:
                begin
                    overlay_enable_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // snaptex tint level
    assign tinted   = (cls_reg >= 8'd2) && (cls_reg <= 8'd5);
    assign hue_idx  = 2'(cls_reg[1:0] - 2'd2);
    assign hue      = snap_rgb(cls_reg);
    assign gmin_sel = gmin_reg[hue_idx];
    assign level    = (pix_reg > gmin_sel) ? pix_reg : gmin_sel;
    assign lit      = (pix_reg > LEVEL_MIN) ? pix_reg : LEVEL_MIN;

    always_comb
    begin
        ramp_t   = 8'd0;
        ramp_sum = 9'd0;
        case (color_mode_reg)
            MODE_GRAY:
            begin
                base = (pix_reg == 8'd0) ? NAVY : '{r: pix_reg, g: pix_reg, b: pix_reg};
            end
            MODE_SNAP:
            begin
                base = snap_rgb(pix_reg);
            end
            MODE_CLASS:
            begin
                base = class_rgb(pix_reg);
            end
            MODE_SIGNED:
            begin
                if (pix_reg == 8'd0)
                begin
                    base = NAVY;
                end
                else if (pix_reg < 8'd128)
                begin
                    ramp_t   = 8'd128 - pix_reg;
                    ramp_sum = 9'd80 + {ramp_t, 1'b0};
                    base.r   = 8'd40;
                    base.g   = 8'd60 + ramp_t;
                    base.b   = (ramp_sum > 9'd255) ? 8'd255 : ramp_sum[7:0];
                end
                else
                begin
                    ramp_t   = {1'b0, pix_reg[6:0]};
                    ramp_sum = 9'd80 + {ramp_t, 1'b0};
                    base.r   = (ramp_sum > 9'd255) ? 8'd255 : ramp_sum[7:0];
                    base.g   = (ramp_t > 8'd120) ? 8'd0 : 8'd120 - ramp_t;
                    base.b   = 8'd40;
                end
            end
            default:
            begin
                if (pix_reg == 8'd0)
                begin
                    base = NAVY;
                end
                else if (pix_reg < 8'd32)
                begin
                    base = VERR_LOW;
                end
                else if (pix_reg < 8'd96)
                begin
                    base = VERR_MID;
                end
                else
                begin
                    base = VERR_HIGH;
                end
            end
        endcase

        if (color_mode_reg == MODE_SNAPTEX)
        begin
            if (pix_reg == 8'd0)
            begin
                out_rgb_next = tinted ? hue : NAVY;
            end
            else if (tinted)
            begin
                out_rgb_next.r = div255(16'(hue.r) * 16'(level));
                out_rgb_next.g = div255(16'(hue.g) * 16'(level));
                out_rgb_next.b = div255(16'(hue.b) * 16'(level));
            end
            else
            begin
                out_rgb_next = '{r: lit, g: lit, b: lit};
            end
        end
        else if (overlay_enable_reg && (cls_reg == OVERLAY_CLASS))
        begin
            out_rgb_next.r = lit;
            out_rgb_next.g = damp(lit);
            out_rgb_next.b = damp(lit);
        end
        else
        begin
            out_rgb_next = base;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = out_rgb_reg.r;
    assign green     = out_rgb_reg.g;
    assign blue      = out_rgb_reg.b;

endmodule

`default_nettype wire

// File: rtl/core/dpc_checker.sv
`default_nettype none

`include "assert_macros.svh"

module dpc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] red,
    input wire logic [7:0] green,
    input wire logic [7:0] blue
);

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable({red, green, blue}))

    // back-pressure only when the result register is full and stalled
    `ASSERT_IMPLIES(a_stall_src, clk, rst_n, !in_ready, out_valid && !out_ready)

    // a fresh result comes from an accepted item that went straight through the input register
    `ASSERT_IMPLIES(a_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind diagnostic_pixel_colorizer dpc_checker u_dpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
);

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_BLOCKS  = 16;
    localparam int BLOCK_ITEMS    = 69;

    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam logic [2:0] MODE_SPARE = 3'd7;

    localparam rgb_t SNAP_HUES [6] = '{
        {8'd12,  8'd14,  8'd40},
        {8'd110, 8'd110, 8'd110},
        {8'd33,  8'd204, 8'd64},
        {8'd224, 8'd31,  8'd31},
        {8'd245, 8'd140, 8'd25},
        {8'd230, 8'd217, 8'd38}
    };

    localparam rgb_t CLASS_HUES [8] = '{
        {8'd12,  8'd14,  8'd40},
        {8'd150, 8'd150, 8'd150},
        {8'd220, 8'd30,  8'd30},
        {8'd240, 8'd140, 8'd20},
        {8'd60,  8'd90,  8'd150},
        {8'd230, 8'd20,  8'd210},
        {8'd30,  8'd200, 8'd190},
        {8'd110, 8'd230, 8'd90}
    };

    localparam logic [7:0] EDGE_VALUES [13] = '{
        8'd0, 8'd1, 8'd31, 8'd32, 8'd39, 8'd40, 8'd95,
        8'd96, 8'd127, 8'd128, 8'd129, 8'd248, 8'd255
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] pixel_value;
    logic [7:0] overlay_class;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    logic [2:0] cur_mode;
    logic [7:0] cur_floor;
    logic       cur_overlay;

    rgb_t pending_colours [$];
    rgb_t want;
    int   mismatches     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_len       = 0;
    int   quiet_cycles   = 0;

    always #4 clk = ~clk;

    diagnostic_pixel_colorizer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_value   (pixel_value),
        .overlay_class (overlay_class),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic rgb_t mk_rgb(input int unsigned r, input int unsigned g,
                                    input int unsigned b);
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function automatic int unsigned sat8(input int unsigned x);
        return (x > 255) ? 255 : x;
    endfunction

    function automatic rgb_t colour_of(input logic [7:0] v, input logic [7:0] cls);
        rgb_t        c;
        int unsigned lvl;
        int unsigned t;
        int unsigned hmax;
        int unsigned gmin;
        lvl = (v < LEVEL_MIN) ? LEVEL_MIN : v;
        if (cur_mode == MODE_SNAPTEX) begin
            if (cls < 8'd2 || cls > 8'd5)
                return (v == 8'd0) ? NAVY : mk_rgb(lvl, lvl, lvl);
            c = SNAP_HUES[cls];
            if (v == 8'd0)
                return c;
            hmax = c.r;
            if (c.g > hmax)
                hmax = c.g;
            if (c.b > hmax)
                hmax = c.b;
            gmin = (int'(cur_floor) * 255 + hmax - 1) / hmax;
            t = (v > gmin) ? v : gmin;
            t = sat8(t);
            return mk_rgb(c.r * t / 255, c.g * t / 255, c.b * t / 255);
        end
        case (cur_mode)
            MODE_GRAY:
                c = (v == 8'd0) ? NAVY : mk_rgb(v, v, v);
            MODE_SNAP:
                if (v < 8'd6)
                    c = SNAP_HUES[v];
                else
                    c = BLACK;
            MODE_CLASS:
                if (v < 8'd8)
                    c = CLASS_HUES[v];
                else
                    c = BLACK;
            MODE_SIGNED:
                if (v == 8'd0)
                    c = NAVY;
                else if (v < 8'd128)
                begin
                    t = 128 - v;
                    c = mk_rgb(40, sat8(60 + t), sat8(80 + 2 * t));
                end
                else
                begin
                    t = v - 128;
                    c = mk_rgb(sat8(80 + 2 * t), (t > 120) ? 0 : 120 - t, 40);
                end
            default:
                if (v == 8'd0)
                    c = NAVY;
                else if (v < 8'd32)
                    c = VERR_LOW;
                else if (v < 8'd96)
                    c = VERR_MID;
                else
                    c = VERR_HIGH;
        endcase
        if (cur_overlay && cls == OVERLAY_CLASS)
            c = mk_rgb(lvl, lvl * 3 / 10, lvl * 3 / 10);
        return c;
    endfunction

    function automatic logic [7:0] random_value();
        if ($urandom_range(9) < 3)
            return EDGE_VALUES[$urandom_range(12)];
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] random_class();
        if ($urandom_range(9) < 7)
            return 8'($urandom_range(8));
        return 8'($urandom);
    endfunction

    task automatic send_pixel(input logic [7:0] v, input logic [7:0] cls);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        pixel_value   <= v;
        overlay_class <= cls;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_colours.push_back(colour_of(v, cls));
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_colours.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COLOR_MODE:     cur_mode    = data[2:0];
            REG_TINT_FLOOR:     cur_floor   = data;
            REG_OVERLAY_ENABLE: cur_overlay = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] mode, input logic [7:0] floor_lvl,
                             input logic ov);
        wait_results();
        write_reg(REG_COLOR_MODE, {5'($urandom), mode});
        write_reg(REG_TINT_FLOOR, floor_lvl);
        write_reg(REG_OVERLAY_ENABLE, {7'($urandom), ov});
    endtask

    task automatic test_reset_values();
        send_pixel(8'd0, OVERLAY_CLASS);
        send_pixel(8'd255, 8'd255);
    endtask

    task automatic test_palettes();
        configure(MODE_SNAP, TINT_FLOOR_RST, 1'b0);
        send_pixel(8'd5, 8'd0);
        send_pixel(8'd6, 8'd1);
        configure(MODE_CLASS, TINT_FLOOR_RST, 1'b0);
        send_pixel(8'd7, 8'd3);
        send_pixel(8'd8, 8'd2);
    endtask

    task automatic test_signed_ramp();
        configure(MODE_SIGNED, TINT_FLOOR_RST, 1'b0);
        send_pixel(8'd1, 8'd0);
        send_pixel(8'd127, 8'd0);
        send_pixel(8'd128, 8'd0);
        send_pixel(8'd255, 8'd0);
    endtask

    task automatic test_verr_bands();
        configure(MODE_SPARE, TINT_FLOOR_RST, 1'b0);
        send_pixel(8'd31, 8'd0);
        send_pixel(8'd32, 8'd0);
        send_pixel(8'd96, 8'd0);
    endtask

    task automatic test_overlay();
        configure(MODE_GRAY, TINT_FLOOR_RST, 1'b1);
        send_pixel(8'd0, OVERLAY_CLASS);
        send_pixel(8'd255, OVERLAY_CLASS);
        send_pixel(8'd100, 8'd5);
    endtask

    task automatic test_snaptex();
        configure(MODE_SNAPTEX, 8'd255, 1'b1);
        send_pixel(8'd1, 8'd2);
        send_pixel(8'd0, 8'd5);
        send_pixel(8'd0, 8'd6);
        send_pixel(8'd39, 8'd1);
        send_pixel(8'd200, OVERLAY_CLASS);
        configure(MODE_SNAPTEX, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd3);
        send_pixel(8'd1, OVERLAY_CLASS);
    endtask

    task automatic test_random_streams();
        logic [7:0] floor_lvl;
        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            case (b % 3)
                0:       floor_lvl = 8'd0;
                1:       floor_lvl = 8'd255;
                default: floor_lvl = 8'($urandom);
            endcase
            configure(3'(b % 8), floor_lvl, 1'($urandom));
            if (b % 4 == 3)
                write_reg(REG_SPARE, 8'($urandom));
            case ((b + b / 8) % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            repeat (BLOCK_ITEMS) send_pixel(random_value(), random_class());
        end
    endtask

    task automatic test_backpressure();
        configure(MODE_SIGNED, TINT_FLOOR_RST, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // hold the output long enough for the input side to stall
        hold_len = 150;
        repeat (12) send_pixel(random_value(), random_class());
    endtask

    initial
    begin
        int n;
        out_ready <= 1'b0;
        forever
        begin
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
                repeat (n)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_colours.size() == 0)
            begin
                $error("unexpected item: red %0d, green %0d, blue %0d", red, green, blue);
                mismatches++;
            end
            else
            begin
                want = pending_colours.pop_front();
                if (red !== want.r)
                begin
                    $error("red: expected %0d, got %0d", want.r, red);
                    mismatches++;
                end
                if (green !== want.g)
                begin
                    $error("green: expected %0d, got %0d", want.g, green);
                    mismatches++;
                end
                if (blue !== want.b)
                begin
                    $error("blue: expected %0d, got %0d", want.b, blue);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        pixel_value   <= 8'd0;
        overlay_class <= 8'd0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_COLOR_MODE;
        cfg_data      <= 8'd0;
        cur_mode    = MODE_GRAY;
        cur_floor   = TINT_FLOOR_RST;
        cur_overlay = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_palettes();
        test_signed_ramp();
        test_verr_bands();
        test_overlay();
        test_snaptex();
        test_random_streams();
        test_backpressure();
        wait_results();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
